// ----- design/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication from a trigger to a consequence in the same cycle.
`define BFBA_ASSERT_IMP(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// An implication from a trigger to a consequence in the next cycle.
`define BFBA_ASSERT_NXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bfba_pkg.sv -----
// Types and constants of the best-fit block allocator.
// Used by bfba_cell and best_fit_block_allocator; depends on nothing.
package bfba_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CFG_W  = 17;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_DONE  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_ROTATE = 3'd1,
    OP_LOAD   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5
  } op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
    logic              used;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t ent;
  } cmd_t;

endpackage

// ----- design/bfba_cell.sv -----
// One table slot of the allocator: holds a block entry and trades it with its neighbors.
// Depends on bfba_pkg.
module bfba_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  bfba_pkg::cmd_t    cmd_i,
  input  logic [IW-1:0]     idx_i,
  input  bfba_pkg::entry_t  prev_i,
  input  bfba_pkg::entry_t  next_i,
  output bfba_pkg::entry_t  ent_o
);

  localparam logic [IW:0] MY = (IW+1)'(IDX);

  bfba_pkg::entry_t ent_q, ent_d;
  logic [IW:0]      idx_x;

  assign idx_x = {1'b0, idx_i};

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      bfba_pkg::OP_ROTATE: ent_d = next_i;
      bfba_pkg::OP_LOAD: begin
        if (idx_x == MY) ent_d = cmd_i.ent;
      end
      bfba_pkg::OP_WRITE: begin
        if (idx_x == MY) begin
          ent_d.size = cmd_i.ent.size;
          ent_d.used = cmd_i.ent.used;
        end
      end
      bfba_pkg::OP_INSERT: begin
        if (MY > idx_x + 1'b1) ent_d = prev_i;
        else if (MY == idx_x + 1'b1) ent_d = cmd_i.ent;
      end
      bfba_pkg::OP_REMOVE: begin
        if (MY >= idx_x) ent_d = next_i;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- design/best_fit_block_allocator.sv -----
// Best-fit block allocator: a row of MAX_BLOCKS cells holds the address-ordered block table.
// Init, done and requests that fail before any table access go straight to the result state.
// Allocate and free rotate the whole row once past the controller in the scan state.
// They then edit the table in the write state and, where needed, in the edit states,
// and present the result in the result state. One beat is in work at a time, and a
// result beat still waiting on the output holds the block in its result state.
// Depends on bfba_pkg, bfba_cell and assert_macros.svh.
`include "assert_macros.svh"

module best_fit_block_allocator #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action, [17:2] request_size, [33:18] free_address, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [16:1] address, [23:17] zero
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned AW = bfba_pkg::ADDR_W;
  localparam logic [AW:0] HDR = (AW+1)'(HEADER_BYTES);
  localparam logic [AW:0] LIM = (AW+1)'(1) << AW;
  localparam logic [IW:0] MAXC = (IW+1)'(MAX_BLOCKS);
  localparam logic [IW-1:0] LASTJ = IW'(MAX_BLOCKS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_WRITE  = 6'b000100,
    ST_EDIT1  = 6'b001000,
    ST_EDIT2  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW:0] count_q, count_d;
  logic ready_q, ready_d;
  logic [16:0] pool_q;
  bfba_pkg::act_e act_q, act_d;
  logic [AW-1:0] req_q, req_d, faddr_q, faddr_d;
  logic found_q, found_d;
  logic [IW-1:0] best_q, best_d;
  logic [AW-1:0] boff_q, boff_d, bsize_q, bsize_d;
  logic hit_q, hit_d, hused_q, hused_d;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [AW-1:0] csize_q, csize_d;
  bfba_pkg::entry_t last_q, last_d;
  logic pused_q, pused_d;
  logic [AW-1:0] psize_q, psize_d;
  logic grab_q, grab_d, nvalid_q, nvalid_d, nused_q, nused_d;
  logic [AW-1:0] nsize_q, nsize_d;
  logic res_st_q, res_st_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic out_valid_q, out_valid_d, out_st_q, out_st_d;
  logic [AW-1:0] out_addr_q, out_addr_d;

  bfba_pkg::cmd_t cmd;
  logic [IW-1:0] cmd_idx;
  bfba_pkg::entry_t ent [MAX_BLOCKS];
  bfba_pkg::entry_t head;

  logic s_fire, vld, fits, match, split, mp, mn;
  logic [AW:0] pb, nadd, merged;
  bfba_pkg::act_e act_in;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign act_in = bfba_pkg::act_e'(s_axis_tdata[1:0]);
  assign head = ent[0];
  assign pb = (pool_q > LIM) ? LIM : pool_q;
  assign vld = ({1'b0, j_q} < count_q);
  assign fits = vld && !head.used && (head.size >= req_q) && (!found_q || bsize_q > head.size);
  assign match = vld && !hit_q && (({1'b0, head.off} + HDR) == {1'b0, faddr_q});
  assign split = (({1'b0, bsize_q}) > ({1'b0, req_q} + HDR)) && (count_q < MAXC);
  assign mp = (hidx_q != '0) && !pused_q;
  assign mn = nvalid_q && !nused_q;
  assign nadd = mn ? ({1'b0, nsize_q} + HDR) : '0;
  assign merged = mp ? ({1'b0, psize_q} + {1'b0, csize_q} + HDR + nadd)
                     : ({1'b0, csize_q} + nadd);

  always_comb begin
    state_d = state_q;  j_d = j_q;  count_d = count_q;  ready_d = ready_q;
    act_d = act_q;  req_d = req_q;  faddr_d = faddr_q;
    found_d = found_q;  best_d = best_q;  boff_d = boff_q;  bsize_d = bsize_q;
    hit_d = hit_q;  hused_d = hused_q;  hidx_d = hidx_q;  csize_d = csize_q;
    last_d = last_q;  pused_d = pused_q;  psize_d = psize_q;
    grab_d = grab_q;  nvalid_d = nvalid_q;  nused_d = nused_q;  nsize_d = nsize_q;
    res_st_d = res_st_q;  res_addr_d = res_addr_q;
    out_st_d = out_st_q;  out_addr_d = out_addr_q;
    cmd.op = bfba_pkg::OP_HOLD;
    cmd.ent = '0;
    cmd_idx = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          act_d = act_in;
          req_d = s_axis_tdata[17:2];
          faddr_d = s_axis_tdata[33:18];
          found_d = 1'b0;  hit_d = 1'b0;  grab_d = 1'b0;  nvalid_d = 1'b0;
          res_st_d = 1'b1;  res_addr_d = '0;
          state_d = ST_RESULT;
          case (act_in)
            bfba_pkg::ACT_INIT: begin
              if (pb > HDR) begin
                cmd.op = bfba_pkg::OP_LOAD;
                cmd.ent.size = AW'(pb - HDR);
                count_d = (IW+1)'(1);
                ready_d = 1'b1;
                res_st_d = 1'b0;
              end
            end
            bfba_pkg::ACT_DONE: begin
              ready_d = 1'b0;
              count_d = '0;
              res_st_d = 1'b0;
            end
            default: begin
              if (ready_q && !(act_in == bfba_pkg::ACT_ALLOC && s_axis_tdata[17:2] == '0)) begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.op = bfba_pkg::OP_ROTATE;
        j_d = j_q + 1'b1;
        last_d = head;
        if (act_q == bfba_pkg::ACT_ALLOC) begin
          if (fits) begin
            found_d = 1'b1;  best_d = j_q;  boff_d = head.off;  bsize_d = head.size;
          end
        end else begin
          if (match) begin
            hit_d = 1'b1;  hidx_d = j_q;  hused_d = head.used;  csize_d = head.size;
            pused_d = last_q.used;  psize_d = last_q.size;  grab_d = 1'b1;
          end
          if (grab_q) begin
            grab_d = 1'b0;  nvalid_d = vld;  nused_d = head.used;  nsize_d = head.size;
          end
        end
        if (j_q == LASTJ) begin
          j_d = '0;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_RESULT;
        cmd.op = bfba_pkg::OP_WRITE;
        if (act_q == bfba_pkg::ACT_ALLOC) begin
          if (found_q) begin
            cmd_idx = best_q;
            cmd.ent.size = split ? req_q : bsize_q;
            cmd.ent.used = 1'b1;
            res_st_d = 1'b0;
            res_addr_d = AW'({1'b0, boff_q} + HDR);
            if (split) state_d = ST_EDIT1;
          end else begin
            cmd.op = bfba_pkg::OP_HOLD;
          end
        end else begin
          if (hit_q && hused_q) begin
            cmd_idx = mp ? (hidx_q - 1'b1) : hidx_q;
            cmd.ent.size = merged[AW-1:0];
            cmd.ent.used = 1'b0;
            res_st_d = 1'b0;
            if (mp || mn) state_d = ST_EDIT1;
          end else begin
            cmd.op = bfba_pkg::OP_HOLD;
          end
        end
      end
      ST_EDIT1: begin
        state_d = ST_RESULT;
        if (act_q == bfba_pkg::ACT_ALLOC) begin
          cmd.op = bfba_pkg::OP_INSERT;
          cmd_idx = best_q;
          cmd.ent.off = AW'({1'b0, boff_q} + HDR + {1'b0, req_q});
          cmd.ent.size = AW'({1'b0, bsize_q} - {1'b0, req_q} - HDR);
          cmd.ent.used = 1'b0;
          count_d = count_q + 1'b1;
        end else begin
          cmd.op = bfba_pkg::OP_REMOVE;
          cmd_idx = mp ? hidx_q : (hidx_q + 1'b1);
          count_d = count_q - 1'b1;
          if (mp && mn) state_d = ST_EDIT2;
        end
      end
      ST_EDIT2: begin
        cmd.op = bfba_pkg::OP_REMOVE;
        cmd_idx = hidx_q;
        count_d = count_q - 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_st_d = res_st_q;
          out_addr_d = res_addr_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (state_q == ST_RESULT && (!out_valid_q || m_axis_tready)) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q <= '0;
      count_q <= '0;
      ready_q <= 1'b0;
      pool_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q <= j_d;
      count_q <= count_d;
      ready_q <= ready_d;
      if (cfg_we_i) pool_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  req_q <= req_d;  faddr_q <= faddr_d;
    found_q <= found_d;  best_q <= best_d;  boff_q <= boff_d;  bsize_q <= bsize_d;
    hit_q <= hit_d;  hused_q <= hused_d;  hidx_q <= hidx_d;  csize_q <= csize_d;
    last_q <= last_d;  pused_q <= pused_d;  psize_q <= psize_d;
    grab_q <= grab_d;  nvalid_q <= nvalid_d;  nused_q <= nused_d;  nsize_q <= nsize_d;
    res_st_q <= res_st_d;  res_addr_q <= res_addr_d;
    out_st_q <= out_st_d;  out_addr_q <= out_addr_d;
  end

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    localparam int unsigned NX = (k + 1) % MAX_BLOCKS;
    localparam int unsigned PV = (k + MAX_BLOCKS - 1) % MAX_BLOCKS;
    bfba_cell #(.IW(IW), .IDX(k)) u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd),
      .idx_i (cmd_idx),
      .prev_i(ent[PV]),
      .next_i(ent[NX]),
      .ent_o (ent[k])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {7'd0, out_addr_q, out_st_q};

  `BFBA_ASSERT(a_count_max, count_q <= MAXC, "block count above table size")
  `BFBA_ASSERT_IMP(a_idle_empty, !ready_q, count_q == '0, "blocks held while pool disabled")
  `BFBA_ASSERT_IMP(a_scan_idle, state_q != ST_SCAN, j_q == '0, "scan counter left running")
  `BFBA_ASSERT_NXT(a_busy, s_fire, state_q != ST_IDLE, "beat accepted without work")

endmodule
